// File: design/rme_pkg.sv
// Shared types, constants and helper functions for the rotation matrix to Euler angle block.
package rme_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TAB_LEN = 24;
   localparam int SQRT_STEPS = 16;
   localparam int XW = 34;
   localparam int ZW = 36;

   localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

   localparam logic [2:0] MODE_XYZ = 3'd0;
   localparam logic [2:0] MODE_XZY = 3'd1;
   localparam logic [2:0] MODE_YXZ = 3'd2;
   localparam logic [2:0] MODE_YZX = 3'd3;
   localparam logic [2:0] MODE_ZXY = 3'd4;
   localparam logic [2:0] MODE_ZYX = 3'd5;

   typedef struct packed {
      logic [2:0] mode;
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [15:0] first_angle;
      logic signed [15:0] middle_angle;
      logic signed [15:0] last_angle;
      logic unique_res;
   } rsp_type;

   typedef struct packed {
      logic [3:0] mid;
      logic mid_neg;
      logic [3:0] fy;
      logic fy_neg;
      logic [3:0] fx;
      logic [3:0] ly;
      logic ly_neg;
      logic [3:0] lx;
      logic [3:0] gy;
      logic gy_neg;
      logic [3:0] gx;
      logic ok;
   } sel_type;

   typedef struct packed {
      logic lock;
      logic neg;
      logic ok;
   } ctl_type;

   typedef struct packed {
      logic signed [15:0] s;
      logic signed [16:0] fy;
      logic signed [16:0] fx;
      logic signed [16:0] ly;
      logic signed [16:0] lx;
      ctl_type ctl;
   } side_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   function automatic sel_type sel_of(logic [2:0] mode);
      sel_type t;
      t = '0;
      unique case (mode)
         MODE_XYZ: t = '{4'd2, 1'b0, 4'd5, 1'b1, 4'd8, 4'd1, 1'b1, 4'd0, 4'd3, 1'b0, 4'd4, 1'b1};
         MODE_XZY: t = '{4'd1, 1'b1, 4'd7, 1'b0, 4'd4, 4'd2, 1'b0, 4'd0, 4'd6, 1'b1, 4'd8, 1'b1};
         MODE_YXZ: t = '{4'd5, 1'b1, 4'd2, 1'b0, 4'd8, 4'd3, 1'b0, 4'd4, 4'd1, 1'b1, 4'd0, 1'b1};
         MODE_YZX: t = '{4'd3, 1'b0, 4'd6, 1'b1, 4'd0, 4'd5, 1'b1, 4'd4, 4'd7, 1'b0, 4'd8, 1'b1};
         MODE_ZXY: t = '{4'd7, 1'b0, 4'd1, 1'b1, 4'd4, 4'd6, 1'b1, 4'd8, 4'd2, 1'b0, 4'd0, 1'b1};
         MODE_ZYX: t = '{4'd6, 1'b1, 4'd3, 1'b0, 4'd0, 4'd7, 1'b0, 4'd8, 4'd1, 1'b1, 4'd2, 1'b1};
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic signed [16:0] pick(req_type r, logic [3:0] idx, logic neg);
      logic signed [15:0] v;
      logic signed [16:0] w;
      unique case (idx)
         4'd0: v = r.m00;
         4'd1: v = r.m01;
         4'd2: v = r.m02;
         4'd3: v = r.m10;
         4'd4: v = r.m11;
         4'd5: v = r.m12;
         4'd6: v = r.m20;
         4'd7: v = r.m21;
         4'd8: v = r.m22;
         default: v = '0;
      endcase
      w = 17'(v);
      return neg ? -w : w;
   endfunction

   function automatic logic signed [ZW-1:0] atan_val(int i);
      logic signed [ZW-1:0] t;
      unique case (i)
         0: t = 36'sh03243F6A8;
         1: t = 36'sh01DAC6705;
         2: t = 36'sh00FADBAFC;
         3: t = 36'sh007F56EA6;
         4: t = 36'sh003FEAB76;
         5: t = 36'sh001FFD55B;
         6: t = 36'sh000FFFAAA;
         7: t = 36'sh0007FFF55;
         8: t = 36'sh0003FFFEA;
         9: t = 36'sh0001FFFFD;
         10: t = 36'sh0000FFFFF;
         11: t = 36'sh00007FFFF;
         12: t = 36'sh00003FFFF;
         13: t = 36'sh00001FFFF;
         14: t = 36'sh00000FFFF;
         15: t = 36'sh000007FFF;
         16: t = 36'sh000003FFF;
         17: t = 36'sh000001FFF;
         18: t = 36'sh000000FFF;
         19: t = 36'sh0000007FF;
         20: t = 36'sh0000003FF;
         21: t = 36'sh0000001FF;
         22: t = 36'sh0000000FF;
         23: t = 36'sh00000007F;
         default: t = '0;
      endcase
      return t;
   endfunction

   // Vectoring setup: scale to Q28 and fold the left half plane over with a +-pi offset.
   function automatic cordic_type cordic_prep(logic signed [16:0] y, logic signed [16:0] x);
      cordic_type c;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      xs = XW'(x) <<< 14;
      ys = XW'(y) <<< 14;
      c.z = '0;
      if (x < 0) begin
         xs = -xs;
         ys = -ys;
         c.z = (y >= 0) ? PI_Q30 : -PI_Q30;
      end
      c.x = xs;
      c.y = ys;
      return c;
   endfunction

   function automatic logic signed [15:0] to_q13(logic signed [ZW-1:0] z);
      logic signed [ZW:0] t;
      logic signed [ZW:0] q;
      t = (ZW+1)'(z) + (ZW+1)'(65536);
      q = t >>> 17;
      if (q > 32767) begin
         return 16'sh7FFF;
      end
      if (q < -32768) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

endpackage

// File: design/rme_sqrt_cell.sv
// One restoring square root step that also carries the pending request fields along.
module rme_sqrt_cell #(
   parameter int BIT_EXP = 0
) (
   input  logic clock,
   input  logic en,
   input  logic [31:0] d_rem,
   input  logic [31:0] d_res,
   input  rme_pkg::side_type d_side,
   output logic [31:0] q_rem,
   output logic [31:0] q_res,
   output rme_pkg::side_type q_side
);
   import rme_pkg::*;

   localparam logic [31:0] BIT_VAL = 32'(1) << BIT_EXP;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   side_type side_ff;
   logic [31:0] trial;

   always_comb begin
      trial = d_res + BIT_VAL;
      if (d_rem >= trial) begin
         rem_in = d_rem - trial;
         res_in = (d_res >> 1) + BIT_VAL;
      end else begin
         rem_in = d_rem;
         res_in = d_res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         side_ff <= d_side;
      end
   end

   assign q_rem = rem_ff;
   assign q_res = res_ff;
   assign q_side = side_ff;
endmodule

// File: design/rme_cordic_cell.sv
// One CORDIC vectoring stage with its output register.
module rme_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic clock,
   input  logic en,
   input  rme_pkg::cordic_type d,
   output rme_pkg::cordic_type q
);
   import rme_pkg::*;

   localparam logic signed [ZW-1:0] ANGLE = atan_val(STAGE);

   cordic_type c_ff, c_in;

   always_comb begin
      c_in = d;
      // A zero y means the vector is already on the axis; later stages leave it alone.
      if (d.y > 0) begin
         c_in.x = d.x + (d.y >>> STAGE);
         c_in.y = d.y - (d.x >>> STAGE);
         c_in.z = d.z + ANGLE;
      end else if (d.y < 0) begin
         c_in.x = d.x - (d.y >>> STAGE);
         c_in.y = d.y + (d.x >>> STAGE);
         c_in.z = d.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in;
      end
   end

   assign q = c_ff;
endmodule

// File: design/rotation_matrix_to_euler.sv
// Top level: rotation matrix to Euler angles for six axis orders, fully pipelined.
//
//   channel | ports                          | direction
//   request | req_valid, req_stall, req_data | in
//   result  | rsp_valid, rsp_stall, rsp_data | out
//
// One request is taken every cycle while the result is not stalled. A request passes
// 20 + CORDIC_STAGES register stages (selection, squaring, 16 square root steps, CORDIC setup,
// the CORDIC stages, output), with CORDIC_STAGES capped at 24. The square root chain and
// the three parallel CORDIC chains set the latency.
// Reset clears only the valid bits of the pipeline and the output register.
// A stalled result freezes the whole pipeline; req_stall follows from it.
module rotation_matrix_to_euler #(
   parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rme_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rme_pkg::rsp_type rsp_data
);
   import rme_pkg::*;

   localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
   localparam int DEPTH = 3 + SQRT_STEPS + NS;

   logic en;
   logic accept;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   sel_type sel;
   side_type side0_in, side0_ff, side1_ff;
   logic signed [16:0] s_raw;
   logic signed [16:0] s_clamp;
   logic lock;
   logic signed [31:0] sq;
   logic [31:0] rem1_ff;

   logic [31:0] rem_w [SQRT_STEPS+1];
   logic [31:0] res_w [SQRT_STEPS+1];
   side_type side_w [SQRT_STEPS+1];

   cordic_type f_w [NS+1];
   cordic_type m_w [NS+1];
   cordic_type l_w [NS+1];
   cordic_type f0_ff, m0_ff, l0_ff;
   ctl_type ctl_ff [NS+1];

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign accept = req_valid && en;

   // Entry selection and clamping of the arcsine argument.
   always_comb begin
      sel = sel_of(req_data.mode);
      s_raw = pick(req_data, sel.mid, sel.mid_neg);
      if (s_raw > ONE_Q14) begin
         s_clamp = ONE_Q14;
      end else if (s_raw < -ONE_Q14) begin
         s_clamp = -ONE_Q14;
      end else begin
         s_clamp = s_raw;
      end
      lock = (s_clamp == ONE_Q14) || (s_clamp == -ONE_Q14);
      side0_in.s = s_clamp[15:0];
      side0_in.fy = lock ? pick(req_data, sel.gy, sel.gy_neg)
                         : pick(req_data, sel.fy, sel.fy_neg);
      side0_in.fx = lock ? pick(req_data, sel.gx, 1'b0) : pick(req_data, sel.fx, 1'b0);
      side0_in.ly = pick(req_data, sel.ly, sel.ly_neg);
      side0_in.lx = pick(req_data, sel.lx, 1'b0);
      side0_in.ctl.lock = lock;
      side0_in.ctl.neg = s_clamp[16];
      side0_in.ctl.ok = sel.ok;
   end

   assign sq = side0_ff.s * side0_ff.s;

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff <= side0_in;
         side1_ff <= side0_ff;
         rem1_ff <= 32'(268435456) - 32'(sq);
      end
   end

   assign rem_w[0] = rem1_ff;
   assign res_w[0] = '0;
   assign side_w[0] = side1_ff;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      rme_sqrt_cell #(
         .BIT_EXP(2 * (SQRT_STEPS - 1 - j))
      ) u_cell (
         .clock(clock),
         .en(en),
         .d_rem(rem_w[j]),
         .d_res(res_w[j]),
         .d_side(side_w[j]),
         .q_rem(rem_w[j+1]),
         .q_res(res_w[j+1]),
         .q_side(side_w[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_ff <= cordic_prep(side_w[SQRT_STEPS].fy, side_w[SQRT_STEPS].fx);
         m0_ff <= cordic_prep(17'(side_w[SQRT_STEPS].s),
                              {1'b0, res_w[SQRT_STEPS][15:0]});
         l0_ff <= cordic_prep(side_w[SQRT_STEPS].ly, side_w[SQRT_STEPS].lx);
         ctl_ff[0] <= side_w[SQRT_STEPS].ctl;
         for (int k = 1; k <= NS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign f_w[0] = f0_ff;
   assign m_w[0] = m0_ff;
   assign l_w[0] = l0_ff;

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      rme_cordic_cell #(.STAGE(i)) u_first (
         .clock(clock), .en(en), .d(f_w[i]), .q(f_w[i+1])
      );
      rme_cordic_cell #(.STAGE(i)) u_mid (
         .clock(clock), .en(en), .d(m_w[i]), .q(m_w[i+1])
      );
      rme_cordic_cell #(.STAGE(i)) u_last (
         .clock(clock), .en(en), .d(l_w[i]), .q(l_w[i+1])
      );
   end

   always_comb begin
      rsp_in = '0;
      if (ctl_ff[NS].ok) begin
         if (ctl_ff[NS].lock) begin
            rsp_in.first_angle = ctl_ff[NS].neg ? to_q13(-f_w[NS].z) : to_q13(f_w[NS].z);
            rsp_in.middle_angle = ctl_ff[NS].neg ? to_q13(-HALF_PI_Q30) : to_q13(HALF_PI_Q30);
            rsp_in.last_angle = '0;
            rsp_in.unique_res = 1'b0;
         end else begin
            rsp_in.first_angle = to_q13(f_w[NS].z);
            rsp_in.middle_angle = to_q13(m_w[NS].z);
            rsp_in.last_angle = to_q13(l_w[NS].z);
            rsp_in.unique_res = 1'b1;
         end
      end
   end

   assign vld_in = {vld_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// File: design/rme_checker.sv
// Port-level checks for the rotation matrix to Euler angle block, bound to the top level.
module rme_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input rme_pkg::req_type req_data,
   input logic rsp_valid,
   input logic rsp_stall,
   input rme_pkg::rsp_type rsp_data
);
   import rme_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   a_lock_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.unique_res |-> rsp_data.last_angle == 16'sd0)
      else $error("last angle not zero for a non-unique result");

   a_lock_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.unique_res |->
         rsp_data.middle_angle == 16'sd12868 || rsp_data.middle_angle == -16'sd12868 ||
         rsp_data.middle_angle == 16'sd0)
      else $error("middle angle not a right angle for a non-unique result");
endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

// File: dv/tb_rotation_matrix_to_euler.sv
// Testbench for the rotation matrix to Euler angle block: random and corner requests, scoreboard check.
module tb_rotation_matrix_to_euler;
   import rme_pkg::*;

   localparam int LATENCY = 20 + CORDIC_STAGES_DEF;
   localparam int NUM_RANDOM = 1200;

   // Per-mode entry selection: mid, mid_neg, fy, fy_neg, fx, ly, ly_neg, lx, gy, gy_neg, gx.
   localparam int ORDER_SEL [6][11] = '{
      '{2, 0, 5, 1, 8, 1, 1, 0, 3, 0, 4},
      '{1, 1, 7, 0, 4, 2, 0, 0, 6, 1, 8},
      '{5, 1, 2, 0, 8, 3, 0, 4, 1, 1, 0},
      '{3, 0, 6, 1, 0, 5, 1, 4, 7, 0, 8},
      '{7, 0, 1, 1, 4, 6, 1, 8, 2, 0, 0},
      '{6, 1, 3, 0, 0, 7, 0, 8, 1, 1, 2}
   };
   localparam longint ARCTAN_Q30 [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };
   localparam longint PI_RAD_Q30 = 64'd3373259426;
   localparam longint HALF_PI_RAD_Q30 = 64'd1686629713;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic req_taken;

   req_type pending_requests[$];
   rsp_type expected_angles[$];
   int send_idle_pct;
   int recv_stall_pct;
   int mismatch_count;

   rotation_matrix_to_euler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   function automatic longint cordic_atan2(longint y, longint x);
      longint xa;
      longint ya;
      longint za;
      longint xold;
      xa = x * 16384;
      ya = y * 16384;
      za = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         xa = -xa;
         ya = -ya;
         za = (y >= 0) ? PI_RAD_Q30 : -PI_RAD_Q30;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
         if (ya == 0) begin
            break;
         end
         xold = xa;
         if (ya > 0) begin
            xa = xa + (ya >>> i);
            ya = ya - (xold >>> i);
            za = za + ARCTAN_Q30[i];
         end else begin
            xa = xa - (ya >>> i);
            ya = ya + (xold >>> i);
            za = za - ARCTAN_Q30[i];
         end
      end
      return za;
   endfunction

   function automatic logic signed [15:0] rad_to_q13(longint z);
      longint q;
      q = (z + 65536) >>> 17;
      if (q > 32767) begin
         q = 32767;
      end
      if (q < -32768) begin
         q = -32768;
      end
      return q[15:0];
   endfunction

   function automatic longint entry_of(req_type r, int idx, int neg);
      longint v;
      case (idx)
         0: v = longint'(r.m00);
         1: v = longint'(r.m01);
         2: v = longint'(r.m02);
         3: v = longint'(r.m10);
         4: v = longint'(r.m11);
         5: v = longint'(r.m12);
         6: v = longint'(r.m20);
         7: v = longint'(r.m21);
         default: v = longint'(r.m22);
      endcase
      return neg ? -v : v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint root;
      root = 0;
      while ((root + 1) * (root + 1) <= v) begin
         root = root + 1;
      end
      return root;
   endfunction

   function automatic rsp_type euler_angles(req_type r);
      rsp_type a;
      longint s;
      longint g;
      int md;
      a = '0;
      md = int'(r.mode);
      if (md < 6) begin
         s = entry_of(r, ORDER_SEL[md][0], ORDER_SEL[md][1]);
         if (s > 16384) s = 16384;
         if (s < -16384) s = -16384;
         if (s == 16384 || s == -16384) begin
            // Gimbal lock: only the combined outer rotation is observable.
            g = cordic_atan2(entry_of(r, ORDER_SEL[md][8], ORDER_SEL[md][9]),
                             entry_of(r, ORDER_SEL[md][10], 0));
            a.middle_angle = rad_to_q13(s > 0 ? HALF_PI_RAD_Q30 : -HALF_PI_RAD_Q30);
            a.first_angle = rad_to_q13(s > 0 ? g : -g);
         end else begin
            a.middle_angle = rad_to_q13(cordic_atan2(s, int_sqrt(268435456 - s * s)));
            a.first_angle = rad_to_q13(cordic_atan2(
               entry_of(r, ORDER_SEL[md][2], ORDER_SEL[md][3]),
               entry_of(r, ORDER_SEL[md][4], 0)));
            a.last_angle = rad_to_q13(cordic_atan2(
               entry_of(r, ORDER_SEL[md][5], ORDER_SEL[md][6]),
               entry_of(r, ORDER_SEL[md][7], 0)));
            a.unique_res = 1'b1;
         end
      end
      return a;
   endfunction

   function automatic req_type random_matrix(logic [2:0] md);
      req_type r;
      logic [159:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = bits[$bits(req_type)-1:0];
      r.mode = md;
      return r;
   endfunction

   // Rotation about one axis by a random angle, with small random noise.
   function automatic req_type rotation_request(logic [2:0] md);
      req_type r;
      real th;
      real c;
      real s;
      th = real'(int'($urandom_range(0, 62831)) - 31415) / 10000.0;
      c = $cos(th) * 16384.0;
      s = $sin(th) * 16384.0;
      r = '0;
      r.mode = md;
      r.m00 = 16'($rtoi(c));
      r.m01 = 16'(-$rtoi(s));
      r.m10 = 16'($rtoi(s));
      r.m11 = 16'($rtoi(c));
      r.m22 = 16'(16384 - int'($urandom_range(0, 3)));
      r.m02 = 16'(int'($urandom_range(0, 8)) - 4);
      r.m12 = 16'(int'($urandom_range(0, 8)) - 4);
      r.m20 = 16'(int'($urandom_range(0, 8)) - 4);
      r.m21 = 16'(int'($urandom_range(0, 8)) - 4);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Remembers whether the request on the bus was taken at the last rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
      end
   end

   // Driver: a new request is presented at the falling edge once the last one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_angles.push_back(euler_angles(req_data));
      end
   end

   // Monitor: each accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_angles.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
               $display("ERROR: unexpected result %h", rsp_data);
            end
         end else if (rsp_data !== expected_angles[0]) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
               $display("ERROR: first %0d/%0d middle %0d/%0d last %0d/%0d unique %0b/%0b",
                        rsp_data.first_angle, expected_angles[0].first_angle,
                        rsp_data.middle_angle, expected_angles[0].middle_angle,
                        rsp_data.last_angle, expected_angles[0].last_angle,
                        rsp_data.unique_res, expected_angles[0].unique_res);
            end
            void'(expected_angles.pop_front());
         end else begin
            void'(expected_angles.pop_front());
         end
      end
   end

   initial begin
      req_type r;
      logic signed [15:0] corner [4];
      corner = '{16'sh7FFF, 16'sh8000, 16'sh4000, -16'sh4000};
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      mismatch_count = 0;
      send_idle_pct = 7;
      recv_stall_pct = 84;

      // Identity, all extremes, unused modes, gimbal lock in both signs and an all-zero matrix.
      for (int md = 0; md < 8; md++) begin
         r = '0;
         r.mode = 3'(md);
         r.m00 = 16'sd16384;
         r.m11 = 16'sd16384;
         r.m22 = 16'sd16384;
         pending_requests.push_back(r);
      end
      for (int k = 0; k < 4; k++) begin
         r = {3'd0, {9{corner[k]}}};
         r.mode = 3'(k);
         pending_requests.push_back(r);
      end
      for (int md = 0; md < 6; md++) begin
         r = random_matrix(3'(md));
         r.m00 = 16'sd0;
         r.m01 = 16'sd0;
         r.m02 = (md % 2) ? 16'sh8000 : 16'sh7FFF;
         r.m10 = (md % 2) ? -16'sd16384 : 16'sd16384;
         r.m12 = 16'sh8000;
         r.m20 = (md % 2) ? 16'sd16384 : -16'sd16384;
         r.m21 = 16'sh8000;
         r.m11 = 16'sd0;
         r.m22 = 16'sd0;
         pending_requests.push_back(r);
      end
      r = '0;
      r.mode = MODE_ZYX;
      pending_requests.push_back(r);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         for (int n = 0; n < NUM_RANDOM / 3; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: pending_requests.push_back(random_matrix(3'($urandom_range(0, 7))));
               3: begin
                  r = rotation_request(3'($urandom_range(0, 5)));
                  r.m02 = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                  pending_requests.push_back(r);
               end
               default: pending_requests.push_back(rotation_request(3'($urandom_range(0, 5))));
            endcase
         end
         wait (pending_requests.size() == 0 && !req_valid);
         if (ph == 0) begin
            send_idle_pct = 84;
            recv_stall_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      end
      wait (expected_angles.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_angles.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
